>>> hw/rtl/lrc_pkg.sv
// Shared types and codes for the line/rectangle clipper.
package lrc_pkg;

  localparam int STATUS_W  = 4;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT   = 2'd0,
    REG_BOTTOM = 2'd1,
    REG_RIGHT  = 2'd2,
    REG_TOP    = 2'd3
  } cfg_reg_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_HIT        = 4'd0,
    ST_H_BELOW    = 4'd1,
    ST_H_ABOVE    = 4'd2,
    ST_V_LEFT     = 4'd3,
    ST_V_RIGHT    = 4'd4,
    ST_RISE_RIGHT = 4'd5,
    ST_RISE_LEFT  = 4'd6,
    ST_FALL_LEFT  = 4'd7,
    ST_FALL_RIGHT = 4'd8
  } status_e;

endpackage

>>> hw/rtl/lrc_if.sv
// Channel interfaces: line input, clip result, configuration write.
interface lrc_line_if #(parameter int COORD_WIDTH = 16) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] slope_rise;
  logic signed [COORD_WIDTH-1:0] slope_run;
  modport source (output valid, point_x, point_y, slope_rise, slope_run, input ready);
  modport sink   (input valid, point_x, point_y, slope_rise, slope_run, output ready);
endinterface

interface lrc_result_if #(parameter int COORD_WIDTH = 16) ();
  logic                          valid;
  logic                          ready;
  logic [lrc_pkg::STATUS_W-1:0]  status;
  logic signed [COORD_WIDTH-1:0] first_x;
  logic signed [COORD_WIDTH-1:0] first_y;
  logic signed [COORD_WIDTH-1:0] second_x;
  logic signed [COORD_WIDTH-1:0] second_y;
  modport source (output valid, status, first_x, first_y, second_x, second_y, input ready);
  modport sink   (input valid, status, first_x, first_y, second_x, second_y, output ready);
endinterface

interface lrc_cfg_if #(parameter int COORD_WIDTH = 16) ();
  logic                          valid;
  logic                          ready;
  logic [lrc_pkg::CFG_IDX_W-1:0] index;
  logic [COORD_WIDTH-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/lrc_div_cell.sv
// One restoring-division step: develops one quotient bit per cycle while en_i is high.
module lrc_div_cell #(
  parameter int W  = 16,
  parameter int QW = 32
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [W-1:0]  rem_i,
  input  logic [QW-1:0] dq_i,
  input  logic [W-1:0]  den_i,
  input  logic          neg_i,
  output logic [W-1:0]  rem_o,
  output logic [QW-1:0] dq_o,
  output logic [W-1:0]  den_o,
  output logic          neg_o
);
  logic [W:0]    trial;
  logic          ge;
  logic [W:0]    diff;
  logic [W-1:0]  rem_d;
  logic [QW-1:0] dq_d;

  always_comb begin
    trial = {rem_i, dq_i[QW-1]};
    ge    = trial >= {1'b0, den_i};
    diff  = trial - {1'b0, den_i};
    rem_d = ge ? diff[W-1:0] : trial[W-1:0];
    dq_d  = {dq_i[QW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      dq_o  <= dq_d;
      den_o <= den_i;
      neg_o <= neg_i;
    end
  end
endmodule

>>> hw/rtl/lrc_div_chain.sv
// Row of division cells: unsigned magnitude quotient, one bit per cell.
module lrc_div_chain #(
  parameter int W  = 16,
  parameter int QW = 32
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [QW-1:0] num_i,
  input  logic [W-1:0]  den_i,
  input  logic          neg_i,
  output logic [QW-1:0] quot_o,
  output logic          neg_o
);
  logic [W-1:0]  rem [QW+1];
  logic [QW-1:0] dq  [QW+1];
  logic [W-1:0]  den [QW+1];
  logic          neg [QW+1];

  assign rem[0] = '0;
  assign dq[0]  = num_i;
  assign den[0] = den_i;
  assign neg[0] = neg_i;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    lrc_div_cell #(.W(W), .QW(QW)) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .rem_i (rem[i]),
      .dq_i  (dq[i]),
      .den_i (den[i]),
      .neg_i (neg[i]),
      .rem_o (rem[i+1]),
      .dq_o  (dq[i+1]),
      .den_o (den[i+1]),
      .neg_o (neg[i+1])
    );
  end

  assign quot_o = dq[QW];
  assign neg_o  = neg[QW];
endmodule

>>> hw/rtl/line_rect_clip_top.sv
// Line against rectangle clipper: front stages, four division rows, select and output.
//
//   channel    dir  beat contents
//   line_i     in   point_x, point_y, slope_rise, slope_run
//   result_o   out  status, first_x, first_y, second_x, second_y
//   cfg_i      in   index (0 left, 1 bottom, 2 right, 3 top), data
//
// One line per clock while result_o is not stalled. Stages in order: input register,
// normalize/difference, multiply, magnitude, 2*COORD_WIDTH division cells
// (one quotient bit each), output register. The whole pipe advances together
// whenever the output register is empty or being taken; a stall at result_o
// freezes every stage, and line_i.ready falls with it. Reset clears the valid
// bits and the rectangle registers (all zero). Config writes are always taken.
module line_rect_clip_top #(
  parameter int COORD_WIDTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lrc_line_if.sink      line_i,
  lrc_result_if.source  result_o,
  lrc_cfg_if.sink       cfg_i
);
  import lrc_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int QW = 2 * W;        // product magnitude width
  localparam int PW = 2 * W + 2;    // signed product width
  localparam int XW = QW + 2;       // end point arithmetic width

  typedef struct packed {
    logic signed [W-1:0] px;
    logic signed [W-1:0] py;
    logic                kx_zero;
    logic                ky_zero;
    logic                rising;
  } side_t;

  // ---------------- rectangle registers ----------------
  logic signed [W-1:0] xmin_q, ymin_q, xmax_q, ymax_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xmin_q <= '0;
      ymin_q <= '0;
      xmax_q <= '0;
      ymax_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_LEFT:   xmin_q <= cfg_i.data;
        REG_BOTTOM: ymin_q <= cfg_i.data;
        REG_RIGHT:  xmax_q <= cfg_i.data;
        REG_TOP:    ymax_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Global advance: output register free or drained this cycle.
  logic out_valid_q;
  logic en;
  assign en           = !out_valid_q || result_o.ready;
  assign line_i.ready = en;

  // ---------------- stage 0: input register ----------------
  logic                v0_q;
  logic signed [W-1:0] px0_q, py0_q, kx0_q, ky0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= line_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px0_q <= line_i.point_x;
      py0_q <= line_i.point_y;
      kx0_q <= line_i.slope_rise;
      ky0_q <= line_i.slope_run;
    end
  end

  // ---------------- stage A: normalize slope, edge distances ----------------
  logic signed [W:0] kx_ext, ky_ext, kxa_d, kya_d;
  logic signed [W:0] dyb_d, dyt_d, dxl_d, dxr_d;
  side_t             sba_d;

  always_comb begin
    kx_ext = {kx0_q[W-1], kx0_q};
    ky_ext = {ky0_q[W-1], ky0_q};
    kxa_d  = kx0_q[W-1] ? -kx_ext : kx_ext;
    kya_d  = kx0_q[W-1] ? -ky_ext : ky_ext;
    dyb_d  = {ymin_q[W-1], ymin_q} - {py0_q[W-1], py0_q};
    dyt_d  = {ymax_q[W-1], ymax_q} - {py0_q[W-1], py0_q};
    dxl_d  = {xmin_q[W-1], xmin_q} - {px0_q[W-1], px0_q};
    dxr_d  = {xmax_q[W-1], xmax_q} - {px0_q[W-1], px0_q};
    sba_d.px      = px0_q;
    sba_d.py      = py0_q;
    sba_d.kx_zero = (kx0_q == '0);
    sba_d.ky_zero = (ky0_q == '0);
    sba_d.rising  = !kya_d[W] && (kya_d != '0);
  end

  logic              va_q;
  logic signed [W:0] kxa_q, kya_q, dyb_q, dyt_q, dxl_q, dxr_q;
  side_t             sba_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else if (en) va_q <= v0_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kxa_q <= kxa_d;
      kya_q <= kya_d;
      dyb_q <= dyb_d;
      dyt_q <= dyt_d;
      dxl_q <= dxl_d;
      dxr_q <= dxr_d;
      sba_q <= sba_d;
    end
  end

  // ---------------- stage B: products ----------------
  // Lanes: 0 bottom x, 1 top x (divide by kx); 2 left y, 3 right y (divide by ky).
  logic               vb_q;
  logic signed [PW-1:0] pb_q [4];
  logic signed [W:0]  kxb_q, kyb_q;
  side_t              sbb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else if (en) vb_q <= va_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pb_q[0] <= dyb_q * kya_q;
      pb_q[1] <= dyt_q * kya_q;
      pb_q[2] <= dxl_q * kxa_q;
      pb_q[3] <= dxr_q * kxa_q;
      kxb_q   <= kxa_q;
      kyb_q   <= kya_q;
      sbb_q   <= sba_q;
    end
  end

  // ---------------- stage C: sign and magnitude ----------------
  logic [PW-1:0] pabs [4];
  logic [QW-1:0] magc_d [4];
  logic          negc_d [4];
  logic [W:0]    kyabs;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pabs[i]   = pb_q[i][PW-1] ? -pb_q[i] : pb_q[i];
      magc_d[i] = pabs[i][QW-1:0];
    end
    // kx is positive after normalization; ky carries the sign.
    negc_d[0] = pb_q[0][PW-1];
    negc_d[1] = pb_q[1][PW-1];
    negc_d[2] = pb_q[2][PW-1] ^ kyb_q[W];
    negc_d[3] = pb_q[3][PW-1] ^ kyb_q[W];
    kyabs     = kyb_q[W] ? -kyb_q : kyb_q;
  end

  // Divisor magnitudes keep W+1 bits: a most-negative slope term negates to 2^(W-1).
  logic          vc_q;
  logic [QW-1:0] magc_q [4];
  logic          negc_q [4];
  logic [W:0]    dkx_q, dky_q;
  side_t         sbc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else if (en) vc_q <= vb_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      magc_q <= magc_d;
      negc_q <= negc_d;
      dkx_q  <= kxb_q;
      dky_q  <= kyabs;
      sbc_q  <= sbb_q;
    end
  end

  // ---------------- division rows ----------------
  logic [QW-1:0] quot [4];
  logic          qneg [4];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    lrc_div_chain #(.W(W + 1), .QW(QW)) u_chain (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (magc_q[l]),
      .den_i  ((l < 2) ? dkx_q : dky_q),
      .neg_i  (negc_q[l]),
      .quot_o (quot[l]),
      .neg_o  (qneg[l])
    );
  end

  // Valid and side data ride alongside the cells.
  logic  vs_q  [QW];
  side_t sbs_q [QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QW; i++) vs_q[i] <= 1'b0;
    end else if (en) begin
      vs_q[0] <= vc_q;
      for (int i = 1; i < QW; i++) vs_q[i] <= vs_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sbs_q[0] <= sbc_q;
      for (int i = 1; i < QW; i++) sbs_q[i] <= sbs_q[i-1];
    end
  end

  // ---------------- end point select ----------------
  function automatic logic signed [W-1:0] sat(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] hi;
    logic signed [XW-1:0] lo;
    hi = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    lo = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
    if (v > hi) return hi[W-1:0];
    if (v < lo) return lo[W-1:0];
    return v[W-1:0];
  endfunction

  side_t                sb;
  logic signed [XW-1:0] q [4];
  logic signed [XW-1:0] pxe, pye, xmin_e, xmax_e, ymin_e, ymax_e;
  logic signed [XW-1:0] xb, xt, yl, yr;
  logic signed [XW-1:0] ax, ay, bx, by;
  status_e              st;

  always_comb begin
    sb = sbs_q[QW-1];
    for (int i = 0; i < 4; i++) begin
      q[i] = qneg[i] ? -$signed({2'b00, quot[i]}) : $signed({2'b00, quot[i]});
    end
    pxe    = {{(XW-W){sb.px[W-1]}}, sb.px};
    pye    = {{(XW-W){sb.py[W-1]}}, sb.py};
    xmin_e = {{(XW-W){xmin_q[W-1]}}, xmin_q};
    xmax_e = {{(XW-W){xmax_q[W-1]}}, xmax_q};
    ymin_e = {{(XW-W){ymin_q[W-1]}}, ymin_q};
    ymax_e = {{(XW-W){ymax_q[W-1]}}, ymax_q};
    xb = pxe + q[0];
    xt = pxe + q[1];
    yl = pye + q[2];
    yr = pye + q[3];
    st = ST_HIT;
    ax = '0; ay = '0; bx = '0; by = '0;
    if (sb.kx_zero) begin
      // horizontal line
      if (pye < ymin_e)      st = ST_H_BELOW;
      else if (pye > ymax_e) st = ST_H_ABOVE;
      else begin
        ax = xmin_e; ay = pye; bx = xmax_e; by = pye;
      end
    end else if (sb.ky_zero) begin
      // vertical line, bottom to top
      if (pxe < xmin_e)      st = ST_V_LEFT;
      else if (pxe > xmax_e) st = ST_V_RIGHT;
      else begin
        ax = pxe; ay = ymin_e; bx = pxe; by = ymax_e;
      end
    end else if (sb.rising) begin
      if (xb > xmax_e)      st = ST_RISE_RIGHT;
      else if (xt < xmin_e) st = ST_RISE_LEFT;
      else begin
        if (xb >= xmin_e) begin ax = xb; ay = ymin_e; end
        else begin ax = xmin_e; ay = yl; end
        if (xt <= xmax_e) begin bx = xt; by = ymax_e; end
        else begin bx = xmax_e; by = yr; end
      end
    end else begin
      if (xb < xmin_e)      st = ST_FALL_LEFT;
      else if (xt > xmax_e) st = ST_FALL_RIGHT;
      else begin
        if (xt >= xmin_e) begin ax = xt; ay = ymax_e; end
        else begin ax = xmin_e; ay = yl; end
        if (xb <= xmax_e) begin bx = xb; by = ymin_e; end
        else begin bx = xmax_e; by = yr; end
      end
    end
  end

  // ---------------- output register ----------------
  status_e             st_q;
  logic signed [W-1:0] ax_q, ay_q, bx_q, by_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= vs_q[QW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q <= st;
      ax_q <= sat(ax);
      ay_q <= sat(ay);
      bx_q <= sat(bx);
      by_q <= sat(by);
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.status   = st_q;
  assign result_o.first_x  = ax_q;
  assign result_o.first_y  = ay_q;
  assign result_o.second_x = bx_q;
  assign result_o.second_y = by_q;
endmodule
